// File: src/fsaz_pkg.sv
package fsaz_pkg;

    localparam int WINDOW_SIZE = 64;
    localparam int CHANNELS    = 6;
    localparam int NUM_OUT_CH  = 6;
    localparam int SIDES       = 2;

    localparam int WORD_W   = 32;
    localparam int THR_W    = 31;
    localparam int LOG2W    = $clog2(WINDOW_SIZE);
    localparam int SLOT_W   = LOG2W;
    localparam int FILL_W   = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W    = WORD_W + LOG2W;
    localparam int DIVCNT_W = $clog2(SUM_W);
    localparam bit WIN_POW2 = ((WINDOW_SIZE & (WINDOW_SIZE - 1)) == 0);

    localparam logic [THR_W-1:0]  THR_RESET = THR_W'(65536);
    localparam logic [WORD_W-1:0] SIGN_BIT  = {1'b1, {(WORD_W-1){1'b0}}};

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        logic              load;
        logic              wr_en;
        logic              rd_en;
        logic              side;
        logic [SLOT_W-1:0] slot;
        logic              acc_clear;
        logic              acc_en;
        logic              div_load;
        logic              div_step;
        logic              commit;
        logic              use_offset;
    } lane_ctrl_t;

    typedef struct packed {
        logic  ok;
        word_t comp;
    } lane_stat_t;

endpackage

// File: src/fsaz_in_if.sv
interface fsaz_in_if;
    logic                  valid;
    logic                  ready;
    logic                  arm_select;
    logic signed [31:0]    sample_ch0;
    logic signed [31:0]    sample_ch1;
    logic signed [31:0]    sample_ch2;
    logic signed [31:0]    sample_ch3;
    logic signed [31:0]    sample_ch4;
    logic signed [31:0]    sample_ch5;

    modport source (
        output valid, arm_select, sample_ch0, sample_ch1, sample_ch2,
               sample_ch3, sample_ch4, sample_ch5,
        input  ready
    );

    modport sink (
        input  valid, arm_select, sample_ch0, sample_ch1, sample_ch2,
               sample_ch3, sample_ch4, sample_ch5,
        output ready
    );
endinterface

// File: src/fsaz_out_if.sv
interface fsaz_out_if;
    logic                  valid;
    logic                  ready;
    logic                  arm_out;
    logic signed [31:0]    comp_ch0;
    logic signed [31:0]    comp_ch1;
    logic signed [31:0]    comp_ch2;
    logic signed [31:0]    comp_ch3;
    logic signed [31:0]    comp_ch4;
    logic signed [31:0]    comp_ch5;
    logic                  zero_found;

    modport source (
        output valid, arm_out, comp_ch0, comp_ch1, comp_ch2, comp_ch3,
               comp_ch4, comp_ch5, zero_found,
        input  ready
    );

    modport sink (
        input  valid, arm_out, comp_ch0, comp_ch1, comp_ch2, comp_ch3,
               comp_ch4, comp_ch5, zero_found,
        output ready
    );
endinterface

// File: src/fsaz_lane.sv
module fsaz_lane (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fsaz_pkg::lane_ctrl_t            ctrl,
    input  logic [fsaz_pkg::THR_W-1:0]      threshold,
    input  fsaz_pkg::word_t                 sample,
    output fsaz_pkg::lane_stat_t            stat
);

    localparam int MEM_DEPTH = fsaz_pkg::SIDES << fsaz_pkg::SLOT_W;

    // Window of both sides; side selects the upper address bit.
    fsaz_pkg::word_t window_mem [MEM_DEPTH];

    fsaz_pkg::word_t                  sample_reg;
    fsaz_pkg::word_t                  rd_data_reg;
    logic [fsaz_pkg::WORD_W-1:0]      lo_reg, lo_next;
    logic [fsaz_pkg::WORD_W-1:0]      hi_reg, hi_next;
    logic [fsaz_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic [fsaz_pkg::SUM_W-1:0]       quo_reg, quo_next;
    logic [fsaz_pkg::LOG2W-1:0]       rem_reg, rem_next;
    fsaz_pkg::word_t                  offset_reg [fsaz_pkg::SIDES];

    logic [fsaz_pkg::WORD_W-1:0]      biased;
    logic [fsaz_pkg::LOG2W:0]         trial;
    logic                             q_bit;
    logic [fsaz_pkg::WORD_W-1:0]      mean_u;
    fsaz_pkg::word_t                  mean;
    logic [fsaz_pkg::WORD_W-1:0]      spread;
    logic signed [fsaz_pkg::WORD_W:0] diff;
    fsaz_pkg::word_t                  sat_diff;
    fsaz_pkg::word_t                  cur_offset;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            window_mem[{ctrl.side, ctrl.slot}] <= sample;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= window_mem[{ctrl.side, ctrl.slot}];
        end
    end

    // Samples are offset by half range so that unsigned compares and sums
    // order them like signed values and the sum never goes negative.
    assign biased = rd_data_reg ^ fsaz_pkg::SIGN_BIT;

    always_comb
    begin
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        sum_next = sum_reg;
        if (ctrl.acc_clear)
        begin
            lo_next  = '1;
            hi_next  = '0;
            sum_next = '0;
        end
        else if (ctrl.acc_en)
        begin
            if (biased < lo_reg)
            begin
                lo_next = biased;
            end
            if (biased > hi_reg)
            begin
                hi_next = biased;
            end
            sum_next = sum_reg + fsaz_pkg::SUM_W'(biased);
        end
    end

    // Restoring division of the biased sum by the window size, one bit a step.
    assign trial = {rem_reg, quo_reg[fsaz_pkg::SUM_W-1]};
    assign q_bit = (trial >= (fsaz_pkg::LOG2W + 1)'(fsaz_pkg::WINDOW_SIZE));

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (ctrl.div_load)
        begin
            quo_next = sum_reg;
            rem_next = '0;
        end
        else if (ctrl.div_step)
        begin
            quo_next = {quo_reg[fsaz_pkg::SUM_W-2:0], q_bit};
            if (q_bit)
            begin
                rem_next = fsaz_pkg::LOG2W'(trial
                           - (fsaz_pkg::LOG2W + 1)'(fsaz_pkg::WINDOW_SIZE));
            end
            else
            begin
                rem_next = trial[fsaz_pkg::LOG2W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sample_reg <= sample;
        end
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        sum_reg <= sum_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    // Removing the bias from the floored quotient gives the floored mean.
    assign mean_u = fsaz_pkg::WIN_POW2 ? sum_reg[fsaz_pkg::LOG2W +: fsaz_pkg::WORD_W]
                                       : quo_reg[fsaz_pkg::WORD_W-1:0];
    assign mean   = mean_u ^ fsaz_pkg::SIGN_BIT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < fsaz_pkg::SIDES; s++)
            begin
                offset_reg[s] <= '0;
            end
        end
        else if (ctrl.commit)
        begin
            offset_reg[ctrl.side] <= mean;
        end
    end

    assign spread     = hi_reg - lo_reg;
    assign cur_offset = offset_reg[ctrl.side];
    assign diff       = {sample_reg[fsaz_pkg::WORD_W-1], sample_reg}
                      - {cur_offset[fsaz_pkg::WORD_W-1], cur_offset};

    always_comb
    begin
        if (diff[fsaz_pkg::WORD_W] != diff[fsaz_pkg::WORD_W-1])
        begin
            sat_diff = diff[fsaz_pkg::WORD_W] ? fsaz_pkg::SIGN_BIT : ~fsaz_pkg::SIGN_BIT;
        end
        else
        begin
            sat_diff = diff[fsaz_pkg::WORD_W-1:0];
        end
    end

    assign stat.ok   = (spread <= {1'b0, threshold});
    assign stat.comp = ctrl.use_offset ? sat_diff : sample_reg;

endmodule

// File: src/force_sensor_auto_zero.sv
// Auto-zero for two six-axis force/torque sensor sides. Each transfer on
// samples carries one Q16.16 sample for one side and yields exactly one
// transfer on results, in order. Until a side has its zero, each sample is
// stored in that side's window; once the window holds WINDOW_SIZE samples,
// every sample triggers a scan of the whole window that checks each
// channel's spread against the threshold and, if all channels are still,
// latches the floored window means as the side's offsets. A scanning item
// reads the window slot by slot through the one read port of each channel's
// window memory; when WINDOW_SIZE is not a power of two, a restoring divider
// then forms the means on success. The threshold is written through
// cfg_we/cfg_data; the user must write it only while the block is idle,
// which the block itself does not enforce.
module force_sensor_auto_zero (
    input  logic                       clk,
    input  logic                       rst_n,
    fsaz_in_if.sink                    samples,
    fsaz_out_if.source                 results,
    input  logic                       cfg_we,
    input  logic [fsaz_pkg::THR_W-1:0] cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DRAIN  = 7'b0000100,
        S_MERGE  = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_COMMIT = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t                           state_reg, state_next;
    logic [fsaz_pkg::THR_W-1:0]       thr_reg;
    logic [fsaz_pkg::SIDES-1:0]       found_reg;
    logic [fsaz_pkg::FILL_W-1:0]      fill_reg [fsaz_pkg::SIDES];
    logic [fsaz_pkg::SLOT_W-1:0]      slot_reg [fsaz_pkg::SIDES];
    logic                             side_reg;
    logic [fsaz_pkg::SLOT_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic [fsaz_pkg::DIVCNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic                             rd_valid_reg;

    logic                             out_valid_reg;
    logic                             out_arm_reg;
    logic                             out_found_reg;
    fsaz_pkg::word_t                  out_comp_reg [fsaz_pkg::NUM_OUT_CH];

    logic                             accept;
    logic                             in_side;
    logic                             win_write;
    logic [fsaz_pkg::FILL_W-1:0]      fill_after;
    logic                             out_load;
    logic                             ok_all;
    fsaz_pkg::lane_ctrl_t             lane_ctrl;
    fsaz_pkg::lane_stat_t             lane_stat [fsaz_pkg::NUM_OUT_CH];
    fsaz_pkg::word_t                  sample_arr [fsaz_pkg::NUM_OUT_CH];

    assign sample_arr[0] = samples.sample_ch0;
    assign sample_arr[1] = samples.sample_ch1;
    assign sample_arr[2] = samples.sample_ch2;
    assign sample_arr[3] = samples.sample_ch3;
    assign sample_arr[4] = samples.sample_ch4;
    assign sample_arr[5] = samples.sample_ch5;

    assign samples.ready = (state_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign in_side       = samples.arm_select;
    assign win_write     = accept && !found_reg[in_side];
    assign fill_after    = (fill_reg[in_side] < fsaz_pkg::FILL_W'(fsaz_pkg::WINDOW_SIZE))
                         ? fill_reg[in_side] + 1'b1 : fill_reg[in_side];
    assign out_load      = (state_reg == S_RESULT) && (!out_valid_reg || results.ready);

    always_comb
    begin
        ok_all = 1'b1;
        for (int c = 0; c < fsaz_pkg::NUM_OUT_CH; c++)
        begin
            ok_all = ok_all & lane_stat[c].ok;
        end
    end

    always_comb
    begin
        lane_ctrl            = '0;
        lane_ctrl.load       = accept;
        lane_ctrl.wr_en      = win_write;
        lane_ctrl.rd_en      = (state_reg == S_SCAN);
        lane_ctrl.side       = accept ? in_side : side_reg;
        lane_ctrl.slot       = accept ? slot_reg[in_side] : scan_cnt_reg;
        lane_ctrl.acc_clear  = accept;
        lane_ctrl.acc_en     = rd_valid_reg;
        lane_ctrl.div_load   = (state_reg == S_MERGE);
        lane_ctrl.div_step   = (state_reg == S_DIV);
        lane_ctrl.commit     = (state_reg == S_COMMIT)
                            || ((state_reg == S_MERGE) && ok_all && fsaz_pkg::WIN_POW2);
        lane_ctrl.use_offset = found_reg[side_reg];
    end

    for (genvar c = 0; c < fsaz_pkg::NUM_OUT_CH; c++)
    begin : g_ch
        if (c < fsaz_pkg::CHANNELS)
        begin : g_lane
            fsaz_lane u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (lane_ctrl),
                .threshold (thr_reg),
                .sample    (sample_arr[c]),
                .stat      (lane_stat[c])
            );
        end
        else
        begin : g_raw
            fsaz_pkg::word_t raw_reg;
            always_ff @(posedge clk)
            begin
                if (accept)
                begin
                    raw_reg <= sample_arr[c];
                end
            end
            assign lane_stat[c].ok   = 1'b1;
            assign lane_stat[c].comp = raw_reg;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        div_cnt_next  = div_cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                scan_cnt_next = '0;
                if (accept)
                begin
                    if (win_write && (fill_after == fsaz_pkg::FILL_W'(fsaz_pkg::WINDOW_SIZE)))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == fsaz_pkg::SLOT_W'(fsaz_pkg::WINDOW_SIZE - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                div_cnt_next = fsaz_pkg::DIVCNT_W'(fsaz_pkg::SUM_W - 1);
                if (ok_all && !fsaz_pkg::WIN_POW2)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_DIV:
            begin
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            thr_reg       <= fsaz_pkg::THR_RESET;
            found_reg     <= '0;
            side_reg      <= 1'b0;
            scan_cnt_reg  <= '0;
            div_cnt_reg   <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < fsaz_pkg::SIDES; s++)
            begin
                fill_reg[s] <= '0;
                slot_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            div_cnt_reg  <= div_cnt_next;
            rd_valid_reg <= (state_reg == S_SCAN);
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
            if (accept)
            begin
                side_reg <= in_side;
            end
            if (win_write)
            begin
                fill_reg[in_side] <= fill_after;
                if (slot_reg[in_side] == fsaz_pkg::SLOT_W'(fsaz_pkg::WINDOW_SIZE - 1))
                begin
                    slot_reg[in_side] <= '0;
                end
                else
                begin
                    slot_reg[in_side] <= slot_reg[in_side] + 1'b1;
                end
            end
            if (lane_ctrl.commit)
            begin
                found_reg[side_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_arm_reg   <= side_reg;
            out_found_reg <= found_reg[side_reg];
            for (int c = 0; c < fsaz_pkg::NUM_OUT_CH; c++)
            begin
                out_comp_reg[c] <= lane_stat[c].comp;
            end
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.arm_out    = out_arm_reg;
    assign results.zero_found = out_found_reg;
    assign results.comp_ch0   = out_comp_reg[0];
    assign results.comp_ch1   = out_comp_reg[1];
    assign results.comp_ch2   = out_comp_reg[2];
    assign results.comp_ch3   = out_comp_reg[3];
    assign results.comp_ch4   = out_comp_reg[4];
    assign results.comp_ch5   = out_comp_reg[5];

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register is not one-hot");

    a_found0_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg[0] |=> found_reg[0])
        else $error("side 0 lost its zero");

    a_found1_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg[1] |=> found_reg[1])
        else $error("side 1 lost its zero");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg[0] <= fsaz_pkg::FILL_W'(fsaz_pkg::WINDOW_SIZE))
        && (fill_reg[1] <= fsaz_pkg::FILL_W'(fsaz_pkg::WINDOW_SIZE)))
        else $error("window fill count above window size");

    a_commit_state: assert property (@(posedge clk) disable iff (!rst_n)
        lane_ctrl.commit |-> (state_reg == S_MERGE || state_reg == S_COMMIT))
        else $error("offset commit outside the merge step");

    a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result shown without a finished item");

endmodule

// File: bench/tb_force_sensor_auto_zero.sv
`timescale 1ns / 100ps

module tb_force_sensor_auto_zero;

    localparam int               CYCLE_LIMIT = 500000;
    localparam int               HOLD_CYCLES = 300;
    localparam fsaz_pkg::word_t  WORD_MAX    = 32'sh7FFF_FFFF;
    localparam fsaz_pkg::word_t  WORD_MIN    = 32'sh8000_0000;

    typedef struct packed {
        logic                                        arm;
        fsaz_pkg::word_t [fsaz_pkg::NUM_OUT_CH-1:0]  ch;
    } sample_t;

    typedef struct packed {
        logic                                        arm;
        fsaz_pkg::word_t [fsaz_pkg::NUM_OUT_CH-1:0]  ch;
        logic                                        found;
    } comp_t;

    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        cfg_we   = 1'b0;
    logic [fsaz_pkg::THR_W-1:0]  cfg_data = '0;
    logic                        rx_hold  = 1'b0;
    event                        hold_go;

    fsaz_in_if  sample_bus ();
    fsaz_out_if result_bus ();

    force_sensor_auto_zero u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (sample_bus),
        .results  (result_bus),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    // Stimulus and expected results.
    sample_t  sample_queue [$];
    comp_t    comp_queue   [$];
    sample_t  offered;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       fail_count     = 0;
    int       cycle_count    = 0;
    longint   band_base [fsaz_pkg::NUM_OUT_CH];

    // Predictor state, one copy per sensor side but for the shared spread limit.
    fsaz_pkg::word_t  win_mem [fsaz_pkg::SIDES][fsaz_pkg::WINDOW_SIZE][fsaz_pkg::CHANNELS];
    int               win_fill    [fsaz_pkg::SIDES];
    int               win_slot    [fsaz_pkg::SIDES];
    fsaz_pkg::word_t  side_offset [fsaz_pkg::SIDES][fsaz_pkg::CHANNELS];
    bit               zero_held   [fsaz_pkg::SIDES];
    logic [fsaz_pkg::THR_W-1:0]  spread_limit = fsaz_pkg::THR_RESET;

    function automatic fsaz_pkg::word_t sat_word(longint v);
        if (v > longint'(WORD_MAX))
            return WORD_MAX;
        if (v < longint'(WORD_MIN))
            return WORD_MIN;
        return fsaz_pkg::word_t'(v);
    endfunction

    function automatic comp_t compensate_sample(sample_t s);
        comp_t            r;
        int               sd;
        int               c;
        int               k;
        longint           lo;
        longint           hi;
        longint           sum;
        longint           v;
        longint           q;
        bit               still;
        fsaz_pkg::word_t  mean [fsaz_pkg::CHANNELS];
        sd = int'(s.arm);
        if (!zero_held[sd])
        begin
            for (c = 0; c < fsaz_pkg::CHANNELS; c++)
                win_mem[sd][win_slot[sd]][c] = s.ch[c];
            win_slot[sd] = (win_slot[sd] + 1) % fsaz_pkg::WINDOW_SIZE;
            if (win_fill[sd] < fsaz_pkg::WINDOW_SIZE)
                win_fill[sd]++;
            if (win_fill[sd] == fsaz_pkg::WINDOW_SIZE)
            begin
                still = 1'b1;
                for (c = 0; c < fsaz_pkg::CHANNELS; c++)
                begin
                    lo  = longint'(win_mem[sd][0][c]);
                    hi  = lo;
                    sum = 0;
                    for (k = 0; k < fsaz_pkg::WINDOW_SIZE; k++)
                    begin
                        v = longint'(win_mem[sd][k][c]);
                        if (v < lo)
                            lo = v;
                        if (v > hi)
                            hi = v;
                        sum += v;
                    end
                    if (hi - lo > longint'(spread_limit))
                        still = 1'b0;
                    // Mean is floored, not truncated toward zero.
                    q = sum / fsaz_pkg::WINDOW_SIZE;
                    if (sum < 0 && (sum % fsaz_pkg::WINDOW_SIZE) != 0)
                        q -= 1;
                    mean[c] = sat_word(q);
                end
                if (still)
                begin
                    for (c = 0; c < fsaz_pkg::CHANNELS; c++)
                        side_offset[sd][c] = mean[c];
                    zero_held[sd] = 1'b1;
                end
            end
        end
        r.arm   = s.arm;
        r.found = zero_held[sd];
        for (c = 0; c < fsaz_pkg::NUM_OUT_CH; c++)
        begin
            r.ch[c] = s.ch[c];
            if (zero_held[sd] && c < fsaz_pkg::CHANNELS)
                r.ch[c] = sat_word(longint'($signed(s.ch[c]))
                                   - longint'(side_offset[sd][c]));
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_result();
        comp_t got;
        comp_t want;
        got.arm   = result_bus.arm_out;
        got.ch[0] = result_bus.comp_ch0;
        got.ch[1] = result_bus.comp_ch1;
        got.ch[2] = result_bus.comp_ch2;
        got.ch[3] = result_bus.comp_ch3;
        got.ch[4] = result_bus.comp_ch4;
        got.ch[5] = result_bus.comp_ch5;
        got.found = result_bus.zero_found;
        if (comp_queue.size() == 0)
        begin
            report_mismatch("unexpected result, arm", 32'(got.arm), 32'd0);
            return;
        end
        want = comp_queue[0];
        comp_queue.delete(0);
        if (got.arm !== want.arm)
            report_mismatch("arm_out", 32'(got.arm), 32'(want.arm));
        for (int c = 0; c < fsaz_pkg::NUM_OUT_CH; c++)
            if (got.ch[c] !== want.ch[c])
                report_mismatch($sformatf("comp_ch%0d", c), got.ch[c], want.ch[c]);
        if (got.found !== want.found)
            report_mismatch("zero_found", 32'(got.found), 32'(want.found));
    endtask

    // Driver: offers queued samples, predicts each one on its transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_bus.valid      <= 1'b0;
            sample_bus.arm_select <= 1'b0;
            sample_bus.sample_ch0 <= '0;
            sample_bus.sample_ch1 <= '0;
            sample_bus.sample_ch2 <= '0;
            sample_bus.sample_ch3 <= '0;
            sample_bus.sample_ch4 <= '0;
            sample_bus.sample_ch5 <= '0;
        end
        else if (!sample_bus.valid || sample_bus.ready)
        begin
            if (sample_bus.valid)
                comp_queue = {comp_queue, compensate_sample(offered)};
            if (sample_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                offered = sample_queue[0];
                sample_queue.delete(0);
                sample_bus.arm_select <= offered.arm;
                sample_bus.sample_ch0 <= offered.ch[0];
                sample_bus.sample_ch1 <= offered.ch[1];
                sample_bus.sample_ch2 <= offered.ch[2];
                sample_bus.sample_ch3 <= offered.ch[3];
                sample_bus.sample_ch4 <= offered.ch[4];
                sample_bus.sample_ch5 <= offered.ch[5];
                sample_bus.valid      <= 1'b1;
            end
            else
            begin
                sample_bus.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transfer and decides on back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
                check_result();
            result_bus.ready <= !rx_hold && ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering meanwhile.
    initial
    begin
        @(hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[force_sensor_auto_zero] ERROR");
            $finish;
        end
    end

    function automatic fsaz_pkg::word_t rand_word();
        case ($urandom_range(7, 0))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            default: return fsaz_pkg::word_t'($urandom);
        endcase
    endfunction

    task automatic push_flat(input logic arm, input fsaz_pkg::word_t v);
        sample_t s;
        s.arm = arm;
        for (int c = 0; c < fsaz_pkg::NUM_OUT_CH; c++)
            s.ch[c] = v;
        sample_queue = {sample_queue, s};
    endtask

    task automatic push_random(input logic arm);
        sample_t s;
        s.arm = arm;
        for (int c = 0; c < fsaz_pkg::NUM_OUT_CH; c++)
            s.ch[c] = rand_word();
        sample_queue = {sample_queue, s};
    endtask

    // Each channel lands at band_base plus a value in [lo, hi].
    task automatic push_band(input logic arm, input int unsigned lo, input int unsigned hi);
        sample_t s;
        s.arm = arm;
        for (int c = 0; c < fsaz_pkg::NUM_OUT_CH; c++)
            s.ch[c] = fsaz_pkg::word_t'(band_base[c] + longint'($urandom_range(hi, lo)));
        sample_queue = {sample_queue, s};
    endtask

    task automatic wait_idle();
        while (sample_queue.size() != 0 || sample_bus.valid || comp_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [fsaz_pkg::THR_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        spread_limit = value;
    endtask

    initial
    begin
        int unsigned  mid_thr;
        int           run_len;
        sample_t      mixed;

        for (int sd = 0; sd < fsaz_pkg::SIDES; sd++)
        begin
            win_fill[sd]  = 0;
            win_slot[sd]  = 0;
            zero_held[sd] = 1'b0;
            for (int c = 0; c < fsaz_pkg::CHANNELS; c++)
                side_offset[sd][c] = '0;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Field extremes on both sides at the reset threshold, no idling.
        push_flat(1'b0, WORD_MAX);
        push_flat(1'b1, WORD_MIN);
        push_flat(1'b0, '0);
        push_flat(1'b1, -32'sd1);
        push_flat(1'b0, 32'sh5555_5555);
        push_flat(1'b1, 32'shAAAA_AAAA);
        push_flat(1'b0, 32'shAAAA_AAAA);
        push_flat(1'b1, 32'sh5555_5555);
        mixed.arm = 1'b1;
        for (int c = 0; c < fsaz_pkg::NUM_OUT_CH; c++)
            mixed.ch[c] = (c % 2 == 0) ? WORD_MAX : WORD_MIN;
        sample_queue = {sample_queue, mixed};
        mixed.arm = 1'b0;
        sample_queue = {sample_queue, mixed};
        push_flat(1'b1, 32'sh0001_0000);
        push_flat(1'b0, -32'sh0001_0000);
        wait_idle();

        // Zero threshold: runs of identical samples that are always broken early.
        write_threshold('0);
        send_idle_pct  = 71;
        recv_stall_pct = 0;
        repeat (3)
        begin
            for (int c = 0; c < fsaz_pkg::NUM_OUT_CH; c++)
                band_base[c] = longint'(fsaz_pkg::word_t'($urandom));
            mixed.arm = 1'($urandom_range(1, 0));
            run_len   = $urandom_range(50, 20);
            repeat (run_len)
                push_band(mixed.arm, 0, 0);
            push_random(mixed.arm);
            repeat (8)
                push_random(1'($urandom_range(1, 0)));
        end
        wait_idle();

        // Largest threshold: side 0 settles in a band near the negative limit.
        write_threshold({fsaz_pkg::THR_W{1'b1}});
        send_idle_pct  = 0;
        recv_stall_pct = 71;
        for (int c = 0; c < fsaz_pkg::NUM_OUT_CH; c++)
            band_base[c] = longint'(WORD_MIN) + longint'($urandom_range(32'h1000_0000, 0));
        repeat (70)
        begin
            push_band(1'b0, 0, 32'h2000_0000);
            if ($urandom_range(2, 0) == 0)
                push_random(1'b1);
        end
        // The offset is far negative here, so a full-scale sample saturates.
        push_flat(1'b0, WORD_MAX);
        push_flat(1'b0, WORD_MIN);
        push_flat(1'b0, '0);
        push_flat(1'b0, -32'sd1);
        wait_idle();

        // Mid threshold: a window with spread one above the limit fails, then one
        // whose spread is exactly the limit is accepted as still.
        mid_thr = $urandom_range(32'h0010_0000, 1000);
        write_threshold(fsaz_pkg::THR_W'(mid_thr));
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        band_base[0] = longint'(WORD_MAX) - longint'(mid_thr) - 1;
        for (int c = 1; c < fsaz_pkg::NUM_OUT_CH; c++)
            band_base[c] = longint'($urandom_range(32'h7FFF_FFFF, 0)) - 64'sd1073741824;
        push_band(1'b1, 0, 0);
        repeat (62)
        begin
            push_band(1'b1, 0, mid_thr);
            if ($urandom_range(5, 0) == 0)
                push_random(1'b0);
        end
        push_band(1'b1, mid_thr + 1, mid_thr + 1);
        push_band(1'b1, 0, 0);
        push_band(1'b1, mid_thr, mid_thr);
        repeat (62)
            push_band(1'b1, 0, mid_thr);
        push_flat(1'b1, WORD_MIN);
        push_flat(1'b1, WORD_MAX);
        repeat (20)
            push_random(1'($urandom_range(1, 0)));
        wait_idle();

        // Receiver holds off for a long stretch while the sender keeps offering.
        write_threshold(fsaz_pkg::THR_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> hold_go;
        repeat (60)
            push_random(1'($urandom_range(1, 0)));
        wait_idle();

        write_threshold(fsaz_pkg::THR_W'($urandom));
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        repeat (25)
            push_random(1'($urandom_range(1, 0)));
        wait_idle();

        repeat (100) @(posedge clk);
        if (comp_queue.size() != 0)
            report_mismatch("results still outstanding", 32'(comp_queue.size()), 32'd0);
        if (fail_count == 0)
            $display("[force_sensor_auto_zero] OK");
        else
            $display("[force_sensor_auto_zero] ERROR");
        $finish;
    end

endmodule
